### design/bfok_pkg.sv
// ----------------------------------------------------------------------------
// bfok_pkg
// Shared types and constants for the binned first-by-order-key block.
// ----------------------------------------------------------------------------
package bfok_pkg;

  localparam int NUM_BINS_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int KEY_BITS_DEF   = 48;
  localparam int IDX_BITS       = 10;
  localparam int FUNC_BITS      = 2;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_ACC   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef struct packed {
    func_t op;
    logic  bin_ok;
  } cmd_ctrl_t;

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_IDLE = 3'b010,
    ST_EXEC = 3'b100
  } back_state_t;

endpackage

### design/bfok_queue.sv
// ----------------------------------------------------------------------------
// bfok_queue
// Short command queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module bfok_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int DEPTH = bfok_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("Queue read while empty.");

endmodule

### design/bfok_front.sv
// ----------------------------------------------------------------------------
// bfok_front
// Accepts input transactions, classifies them and queues the ones that act.
// ----------------------------------------------------------------------------
module bfok_front #(
  parameter int NUM_BINS   = bfok_pkg::NUM_BINS_DEF,
  parameter int VALUE_BITS = bfok_pkg::VALUE_BITS_DEF,
  parameter int KEY_BITS   = bfok_pkg::KEY_BITS_DEF,
  parameter int CMD_W      = 8
) (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bfok_pkg::FUNC_BITS-1:0] func,
  input  logic [bfok_pkg::IDX_BITS-1:0]  bin_index,
  input  logic [VALUE_BITS-1:0]          item_value,
  input  logic [KEY_BITS-1:0]            order_key,
  input  logic                           keep,
  input  logic                           init_done,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [CMD_W-1:0]               q_data
);

  bfok_pkg::cmd_ctrl_t ctrl;
  logic                enq;

  always_comb begin
    ctrl.bin_ok = (32'(bin_index) < 32'(NUM_BINS));
    ctrl.op     = bfok_pkg::FUNC_READ;
    enq         = 1'b0;
    unique case (func)
      bfok_pkg::FUNC_ACC: begin
        ctrl.op = bfok_pkg::FUNC_ACC;
        enq     = keep && ctrl.bin_ok;
      end
      bfok_pkg::FUNC_READ: begin
        ctrl.op = bfok_pkg::FUNC_READ;
        enq     = 1'b1;
      end
      bfok_pkg::FUNC_CLEAR: begin
        ctrl.op = bfok_pkg::FUNC_CLEAR;
        enq     = ctrl.bin_ok;
      end
      default: begin
        enq = 1'b0;
      end
    endcase
  end

  assign in_ready = init_done && (!enq || !q_full);
  assign q_push   = in_valid && in_ready && enq;
  assign q_data   = {order_key, item_value, bin_index, ctrl};

endmodule

### design/bfok_back.sv
// ----------------------------------------------------------------------------
// bfok_back
// Owns the bin memory: clearing pass, read-compare-write and read results.
// ----------------------------------------------------------------------------
module bfok_back #(
  parameter int NUM_BINS   = bfok_pkg::NUM_BINS_DEF,
  parameter int VALUE_BITS = bfok_pkg::VALUE_BITS_DEF,
  parameter int KEY_BITS   = bfok_pkg::KEY_BITS_DEF,
  parameter int CMD_W      = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_data,
  output logic                  init_done,
  input  logic                  q_valid,
  input  logic [CMD_W-1:0]      q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [KEY_BITS-1:0]   out_key,
  output logic                  out_empty
);

  localparam int CTRL_W = $bits(bfok_pkg::cmd_ctrl_t);
  localparam int IDX_W  = bfok_pkg::IDX_BITS;
  localparam int ADDR_W = $clog2(NUM_BINS);
  localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam int MEM_W  = 1 + KEY_BITS + VALUE_BITS;

  logic [MEM_W-1:0] mem [NUM_BINS];

  bfok_pkg::back_state_t state;
  bfok_pkg::back_state_t state_next;

  logic                order_max_mode;
  logic [ADDR_W-1:0]   init_addr;
  bfok_pkg::cmd_ctrl_t cur_ctrl;
  logic [ADDR_W-1:0]   cur_addr;
  logic [VALUE_BITS-1:0] cur_value;
  logic [KEY_BITS-1:0] cur_key;
  logic [MEM_W-1:0]    rdata;

  bfok_pkg::cmd_ctrl_t head_ctrl;
  logic [EXT_W-1:0]    head_idx_ext;
  logic [ADDR_W-1:0]   head_addr;

  logic                rd_empty;
  logic [KEY_BITS-1:0] rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic                newer;
  logic                take;
  logic                out_load;
  logic                we;
  logic [ADDR_W-1:0]   wa;
  logic [MEM_W-1:0]    wd;

  assign head_ctrl    = bfok_pkg::cmd_ctrl_t'(q_data[CTRL_W-1:0]);
  assign head_idx_ext = EXT_W'(q_data[CTRL_W +: IDX_W]);
  assign head_addr    = head_idx_ext[ADDR_W-1:0];

  assign rd_empty = rdata[MEM_W-1];
  assign rd_key   = rdata[VALUE_BITS +: KEY_BITS];
  assign rd_value = rdata[VALUE_BITS-1:0];

  assign newer = order_max_mode ? ($signed(cur_key) > $signed(rd_key))
                                : ($signed(cur_key) < $signed(rd_key));
  assign take  = rd_empty || newer;

  assign init_done = (state != bfok_pkg::ST_INIT);
  assign q_pop     = (state == bfok_pkg::ST_IDLE) && q_valid;
  assign out_load  = (state == bfok_pkg::ST_EXEC) && (cur_ctrl.op == bfok_pkg::FUNC_READ)
                     && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    we         = 1'b0;
    wa         = cur_addr;
    wd         = {1'b0, cur_key, cur_value};
    unique case (state)
      bfok_pkg::ST_INIT: begin
        we = 1'b1;
        wa = init_addr;
        wd = '0;
        wd[MEM_W-1] = 1'b1;
        if (init_addr == ADDR_W'(NUM_BINS - 1)) begin
          state_next = bfok_pkg::ST_IDLE;
        end
      end
      bfok_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = bfok_pkg::ST_EXEC;
        end
      end
      bfok_pkg::ST_EXEC: begin
        case (cur_ctrl.op)
          bfok_pkg::FUNC_ACC: begin
            we         = take;
            state_next = bfok_pkg::ST_IDLE;
          end
          bfok_pkg::FUNC_CLEAR: begin
            we          = 1'b1;
            wd[MEM_W-1] = 1'b1;
            state_next  = bfok_pkg::ST_IDLE;
          end
          default: begin
            if (out_load) begin
              state_next = bfok_pkg::ST_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_next = bfok_pkg::ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (q_pop) begin
      rdata <= mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_ctrl  <= head_ctrl;
      cur_addr  <= head_addr;
      cur_value <= q_data[CTRL_W + IDX_W +: VALUE_BITS];
      cur_key   <= q_data[CTRL_W + IDX_W + VALUE_BITS +: KEY_BITS];
    end
    if (out_load) begin
      if (cur_ctrl.bin_ok && !rd_empty) begin
        out_value <= rd_value;
        out_key   <= rd_key;
        out_empty <= 1'b0;
      end else begin
        out_value <= '0;
        out_key   <= '0;
        out_empty <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bfok_pkg::ST_INIT;
      init_addr      <= '0;
      order_max_mode <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bfok_pkg::ST_INIT) begin
        init_addr <= init_addr + 1'b1;
      end
      if (cfg_valid) begin
        order_max_mode <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_result_in_init: assert property (@(posedge clk) disable iff (rst)
    (state == bfok_pkg::ST_INIT) |-> !out_valid)
    else $error("Result presented during the clearing pass.");

  a_pop_then_exec: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == bfok_pkg::ST_EXEC))
    else $error("Popped command not executed in the next cycle.");

endmodule

### design/binned_first_by_order_key.sv
// ----------------------------------------------------------------------------
// binned_first_by_order_key
// Per-bin first (or last) value by order key, with read and clear commands.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel. An accumulate transaction offers a
// value and an order key to one bin; the bin keeps it when empty or when the
// key is strictly smaller than the stored key (strictly larger when the
// configuration bit selects max mode). A read transaction returns the bin's
// value, key and empty flag on the m_axis channel; clear empties one bin.
// The configuration channel writes the max-mode bit and is always ready.
// After reset the block sweeps all NUM_BINS bins to empty, one per cycle,
// and holds s_axis_tready low until the sweep is done. The back end pops a
// queued command and reads the bin memory in the idle state, then compares
// and writes back or loads a read result in the execute state, and takes no
// new command before the last is done. Dropped items (unused codes, unkept
// rows, out-of-range accumulate and clear) are taken but not queued. A read
// result passes the queue, the bin read register and the output register.
// While m_axis_tready is low the result is held, the back end waits on the
// next read, and the two-entry queue fills before s_axis_tready drops.
// ----------------------------------------------------------------------------
module binned_first_by_order_key #(
  parameter int NUM_BINS   = bfok_pkg::NUM_BINS_DEF,
  parameter int VALUE_BITS = bfok_pkg::VALUE_BITS_DEF,
  parameter int KEY_BITS   = bfok_pkg::KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // bin_index, item_value, order_key, zero padding
  input  logic [((bfok_pkg::IDX_BITS + VALUE_BITS + KEY_BITS + 7) / 8) * 8 - 1:0]
               s_axis_tdata,
  // func, keep
  input  logic [bfok_pkg::FUNC_BITS:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // bin_value, bin_order_key, zero padding
  output logic [((VALUE_BITS + KEY_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // bin_empty
  output logic [0:0] m_axis_tuser
);

  localparam int IDX_W   = bfok_pkg::IDX_BITS;
  localparam int CMD_W   = $bits(bfok_pkg::cmd_ctrl_t) + IDX_W + VALUE_BITS + KEY_BITS;
  localparam int OUT_W   = ((VALUE_BITS + KEY_BITS + 7) / 8) * 8;

  logic                  init_done;
  logic                  q_full;
  logic                  q_push;
  logic [CMD_W-1:0]      q_push_data;
  logic                  q_pop;
  logic                  q_valid;
  logic [CMD_W-1:0]      q_head;
  logic [VALUE_BITS-1:0] out_value;
  logic [KEY_BITS-1:0]   out_key;
  logic                  out_empty;

  assign cfg_ready = 1'b1;

  bfok_front #(
    .NUM_BINS  (NUM_BINS),
    .VALUE_BITS(VALUE_BITS),
    .KEY_BITS  (KEY_BITS),
    .CMD_W     (CMD_W)
  ) u_front (
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .func      (s_axis_tuser[bfok_pkg::FUNC_BITS-1:0]),
    .bin_index (s_axis_tdata[IDX_W-1:0]),
    .item_value(s_axis_tdata[IDX_W +: VALUE_BITS]),
    .order_key (s_axis_tdata[IDX_W + VALUE_BITS +: KEY_BITS]),
    .keep      (s_axis_tuser[bfok_pkg::FUNC_BITS]),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  bfok_queue #(
    .WIDTH(CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_data (q_head)
  );

  bfok_back #(
    .NUM_BINS  (NUM_BINS),
    .VALUE_BITS(VALUE_BITS),
    .KEY_BITS  (KEY_BITS),
    .CMD_W     (CMD_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .init_done(init_done),
    .q_valid  (q_valid),
    .q_data   (q_head),
    .q_pop    (q_pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_value(out_value),
    .out_key  (out_key),
    .out_empty(out_empty)
  );

  assign m_axis_tdata    = OUT_W'({out_key, out_value});
  assign m_axis_tuser[0] = out_empty;

endmodule
